### rtl/octree_cell_address_unit_macros.svh
// ---------------------------------------------------------------------------
// Octree cell address unit assertion macros
// Small wrappers for the concurrent checks of the cell address pipeline.
// ---------------------------------------------------------------------------
`ifndef OCTREE_CELL_ADDRESS_UNIT_MACROS_SVH
`define OCTREE_CELL_ADDRESS_UNIT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define OCAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("octree cell address unit check failed");

// Next-cycle implication, checked only while reset is released.
`define OCAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("octree cell address unit check failed");

`endif

### rtl/ocau_pkg.sv
// ---------------------------------------------------------------------------
// Octree cell address unit package
// Shared widths, register indexes, operation codes and octant digit helpers.
// ---------------------------------------------------------------------------
package ocau_pkg;

    localparam int DEF_MAX_LEVELS = 16;
    localparam int DEF_COORD_BITS = 32;

    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 5;
    localparam int HALF_W    = 31;
    localparam int DEPTH_W   = 5;
    localparam int WIDTH_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 31'd6553600;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 3'd4;

    // Control that travels with each word down the level pipeline.
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
    } t_lvl_ctl;

    // Octant digit from the negative flags of the residual. The low two bits
    // walk the xy quadrants in the order +x+y, -x+y, -x-y, +x-y.
    function automatic logic [2:0] f_enc_digit(input logic xn, input logic yn,
                                               input logic zn);
        return {zn, yn, xn ^ yn};
    endfunction

    // Negative flags {z, y, x} of an octant digit.
    function automatic logic [2:0] f_dig_neg(input logic [2:0] digit);
        return {digit[2], digit[1], digit[1] ^ digit[0]};
    endfunction

endpackage

### rtl/octree_cell_address_unit.sv
// ---------------------------------------------------------------------------
// Octree cell address unit
// Encodes points into octree cell addresses and decodes addresses into cell centers
// and edge lengths, one word per cycle through a level pipeline unless stalled.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  s_axis    in         tvalid/tready          tuser: op; tdata: point, address
//  m_axis    out        tvalid/tready          tdata: address, centers, width
//  cfg       in         i_cfg_we (no wait)     register index and data
//
// The pipeline has an entry stage that forms the residual or loads the root
// center, one stage per tree level, and an output stage that saturates the
// center and forms the cell width. A new word is taken every cycle unless stalled.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stage holds its word only while the next one is full and
// stalled, so a bubble anywhere is filled even while the output waits.
//
module octree_cell_address_unit #(
    parameter int  MAX_LEVELS = ocau_pkg::DEF_MAX_LEVELS,
    parameter int  COORD_BITS = ocau_pkg::DEF_COORD_BITS,
    localparam int CFG_W      = (COORD_BITS > ocau_pkg::HALF_W) ? COORD_BITS
                                                                : ocau_pkg::HALF_W,
    localparam int IN_W       = ((3 * COORD_BITS + ocau_pkg::ADDR_W
                                  + ocau_pkg::LEN_W + 7) / 8) * 8,
    localparam int OUT_W      = ((3 * COORD_BITS + ocau_pkg::ADDR_W
                                  + ocau_pkg::LEN_W + ocau_pkg::WIDTH_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [ocau_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]               i_cfg_data,
    // Query words.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit first: point_x, point_y, point_z, address_in,
    // address_len_in, zero padding.
    input  logic [IN_W-1:0]                s_axis_tdata,
    // tuser: op (0 encode, 1 decode).
    input  logic                           s_axis_tuser,
    // Result words.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit first: address_out, address_len_out, cell_center_x,
    // cell_center_y, cell_center_z, cell_width, zero padding.
    output logic [OUT_W-1:0]               m_axis_tdata
);
    import ocau_pkg::*;

    `include "octree_cell_address_unit_macros.svh"

    // The residual starts within the sum of two coordinates and the level
    // steps add less than the root half size, so two guard bits suffice.
    localparam int RW = ((COORD_BITS > WIDTH_W) ? COORD_BITS : WIDTH_W) + 2;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEVELS);
    // Digits above the deepest level never reach the output.
    localparam int KEEP_LV   = (MAX_LEVELS < ADDR_W / 3) ? MAX_LEVELS : ADDR_W / 3;
    localparam int KEEP_BITS = 3 * KEEP_LV;
    localparam logic [ADDR_W-1:0] ADDR_KEEP = {ADDR_W{1'b1}} >> (ADDR_W - KEEP_BITS);
    localparam logic signed [RW-1:0] SAT_HI =
        {{(RW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO =
        {{(RW - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    // Configuration registers.
    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic signed [COORD_BITS-1:0] r_center_z;
    logic [HALF_W-1:0]            r_half;
    logic [DEPTH_W-1:0]           r_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_half     <= HALF_RESET;
            r_depth    <= DEPTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Z: r_center_z <= i_cfg_data[COORD_BITS-1:0];
                CFG_HALF:     r_half     <= i_cfg_data[HALF_W-1:0];
                CFG_DEPTH:    r_depth    <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the query word.
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [COORD_BITS-1:0] pt_z;
    logic [ADDR_W-1:0]            addr_in;
    logic [LEN_W-1:0]             len_in;

    assign pt_x    = s_axis_tdata[COORD_BITS-1:0];
    assign pt_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pt_z    = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign addr_in = s_axis_tdata[3*COORD_BITS +: ADDR_W];
    assign len_in  = s_axis_tdata[3*COORD_BITS+ADDR_W +: LEN_W];

    // Entry stage: on encode the accumulators hold the point relative to the
    // root center, on decode they start at the root center itself. The level
    // count is limited to the pipeline depth either way.
    t_lvl_ctl             n_s0_ctl;
    logic signed [RW-1:0] n_s0_x;
    logic signed [RW-1:0] n_s0_y;
    logic signed [RW-1:0] n_s0_z;
    logic                 r_s0_valid;
    t_lvl_ctl             r_s0_ctl;
    logic signed [RW-1:0] r_s0_x;
    logic signed [RW-1:0] r_s0_y;
    logic signed [RW-1:0] r_s0_z;

    always_comb begin
        n_s0_ctl.valid = 1'b1;
        n_s0_ctl.op    = s_axis_tuser;
        if (s_axis_tuser == OP_ENCODE) begin
            n_s0_ctl.len  = (r_depth > MAX_LEN) ? MAX_LEN : r_depth;
            n_s0_ctl.addr = '0;
            n_s0_x        = RW'(pt_x) - RW'(r_center_x);
            n_s0_y        = RW'(pt_y) - RW'(r_center_y);
            n_s0_z        = RW'(pt_z) - RW'(r_center_z);
        end else begin
            n_s0_ctl.len  = (len_in > MAX_LEN) ? MAX_LEN : len_in;
            n_s0_ctl.addr = addr_in & ADDR_KEEP;
            n_s0_x        = RW'(r_center_x);
            n_s0_y        = RW'(r_center_y);
            n_s0_z        = RW'(r_center_z);
        end
    end

    // Level pipeline wiring: index k is the output of stage k, stage 0 being
    // the entry stage.
    t_lvl_ctl             ctl   [0:MAX_LEVELS];
    logic signed [RW-1:0] acc_x [0:MAX_LEVELS];
    logic signed [RW-1:0] acc_y [0:MAX_LEVELS];
    logic signed [RW-1:0] acc_z [0:MAX_LEVELS];
    logic                 ready [0:MAX_LEVELS];   // stage k can take a word
    logic                 out_ready;

    assign ready[0]      = !r_s0_valid || ready[1];
    assign s_axis_tready = ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (ready[0]) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0] && s_axis_tvalid) begin
            r_s0_ctl <= n_s0_ctl;
            r_s0_x   <= n_s0_x;
            r_s0_y   <= n_s0_y;
            r_s0_z   <= n_s0_z;
        end
    end

    assign ctl[0]   = {r_s0_valid, r_s0_ctl.op, r_s0_ctl.len, r_s0_ctl.addr};
    assign acc_x[0] = r_s0_x;
    assign acc_y[0] = r_s0_y;
    assign acc_z[0] = r_s0_z;

    // One stage per tree level; a stage past the word's length passes it on.
    for (genvar k = 1; k <= MAX_LEVELS; k++) begin : g_level
        logic ready_dn;
        if (k == MAX_LEVELS) begin : g_last
            assign ready_dn = out_ready;
        end else begin : g_mid
            assign ready_dn = ready[k+1];
        end

        ocau_level #(
            .LEVEL (k),
            .RW    (RW)
        ) u_level (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[k-1]),
            .i_acc_x    (acc_x[k-1]),
            .i_acc_y    (acc_y[k-1]),
            .i_acc_z    (acc_z[k-1]),
            .i_half     (r_half),
            .i_ready_dn (ready_dn),
            .o_ready_up (ready[k]),
            .o_ctl      (ctl[k]),
            .o_acc_x    (acc_x[k]),
            .o_acc_y    (acc_y[k]),
            .o_acc_z    (acc_z[k])
        );
    end

    // Output stage: clamp the decoded center to the coordinate range and form
    // the cell width. Encode words report zero center and width.
    function automatic logic [COORD_BITS-1:0] f_sat(input logic signed [RW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    t_lvl_ctl                last_ctl;
    logic [COORD_BITS-1:0]   n_out_cx;
    logic [COORD_BITS-1:0]   n_out_cy;
    logic [COORD_BITS-1:0]   n_out_cz;
    logic [WIDTH_W-1:0]      n_out_width;
    logic                    r_out_valid;
    logic                    r_out_op;
    logic [ADDR_W-1:0]       r_out_addr;
    logic [LEN_W-1:0]        r_out_len;
    logic [COORD_BITS-1:0]   r_out_cx;
    logic [COORD_BITS-1:0]   r_out_cy;
    logic [COORD_BITS-1:0]   r_out_cz;
    logic [WIDTH_W-1:0]      r_out_width;

    assign last_ctl  = ctl[MAX_LEVELS];
    assign out_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        if (last_ctl.op == OP_DECODE) begin
            n_out_cx    = f_sat(acc_x[MAX_LEVELS]);
            n_out_cy    = f_sat(acc_y[MAX_LEVELS]);
            n_out_cz    = f_sat(acc_z[MAX_LEVELS]);
            n_out_width = {r_half, 1'b0} >> last_ctl.len;
        end else begin
            n_out_cx    = '0;
            n_out_cy    = '0;
            n_out_cz    = '0;
            n_out_width = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= last_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && last_ctl.valid) begin
            r_out_op    <= last_ctl.op;
            r_out_addr  <= last_ctl.addr;
            r_out_len   <= last_ctl.len;
            r_out_cx    <= n_out_cx;
            r_out_cy    <= n_out_cy;
            r_out_cz    <= n_out_cz;
            r_out_width <= n_out_width;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_width, r_out_cz, r_out_cy, r_out_cx,
                                   r_out_len, r_out_addr});

    // A full entry stage is the only reason to refuse a query.
    `OCAU_ASSERT_IMPL(a_in_stall_full, i_clk, i_rst_n, !s_axis_tready, r_s0_valid)
    // An accepted query occupies the entry stage on the next cycle.
    `OCAU_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
                      r_s0_valid)
    // No word ever carries more levels than the pipeline has.
    `OCAU_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, r_out_valid, r_out_len <= MAX_LEN)
    // Encode results leave the decoded fields cleared.
    `OCAU_ASSERT_IMPL(a_enc_zero, i_clk, i_rst_n, r_out_valid && (r_out_op == OP_ENCODE),
                      (r_out_width == '0) && (r_out_cx == '0) && (r_out_cy == '0)
                      && (r_out_cz == '0))

endmodule

### rtl/ocau_level.sv
// ---------------------------------------------------------------------------
// Octree cell address level stage
// One tree level: picks or reads the octant digit and moves the accumulators.
// ---------------------------------------------------------------------------
module ocau_level #(
    parameter int LEVEL = 1,
    parameter int RW    = 34
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ocau_pkg::t_lvl_ctl          i_ctl,
    input  logic signed [RW-1:0]        i_acc_x,
    input  logic signed [RW-1:0]        i_acc_y,
    input  logic signed [RW-1:0]        i_acc_z,
    input  logic [ocau_pkg::HALF_W-1:0] i_half,
    input  logic                        i_ready_dn,
    output logic                        o_ready_up,
    output ocau_pkg::t_lvl_ctl          o_ctl,
    output logic signed [RW-1:0]        o_acc_x,
    output logic signed [RW-1:0]        o_acc_y,
    output logic signed [RW-1:0]        o_acc_z
);
    import ocau_pkg::*;

    localparam logic [LEN_W-1:0] LVL = LEN_W'(LEVEL);
    // Levels past the address field still move the center but keep no digit.
    localparam bit HAS_DIGIT = (3 * LEVEL <= ADDR_W);
    localparam int DLO       = HAS_DIGIT ? 3 * (LEVEL - 1) : 0;

    logic                 active;
    logic [2:0]           digit;
    logic [2:0]           neg;
    logic signed [RW-1:0] hs;
    t_lvl_ctl             n_ctl;
    logic signed [RW-1:0] n_acc_x;
    logic signed [RW-1:0] n_acc_y;
    logic signed [RW-1:0] n_acc_z;
    logic                 r_valid;
    t_lvl_ctl             r_ctl;
    logic signed [RW-1:0] r_acc_x;
    logic signed [RW-1:0] r_acc_y;
    logic signed [RW-1:0] r_acc_z;

    always_comb begin
        active = (i_ctl.len >= LVL);
        hs     = RW'(i_half >> LEVEL);
        if (i_ctl.op == OP_ENCODE) begin
            digit = f_enc_digit(i_acc_x[RW-1], i_acc_y[RW-1], i_acc_z[RW-1]);
        end else if (HAS_DIGIT) begin
            digit = i_ctl.addr[DLO +: 3];
        end else begin
            digit = 3'd0;
        end
        neg   = f_dig_neg(digit);
        n_ctl = i_ctl;
        if (HAS_DIGIT) begin
            n_ctl.addr[DLO +: 3] = active ? digit : 3'd0;
        end
        // Encoding moves the residual toward the octant; decoding moves the
        // center into it, so the sign of the step flips with the operation.
        n_acc_x = i_acc_x;
        n_acc_y = i_acc_y;
        n_acc_z = i_acc_z;
        if (active) begin
            n_acc_x = i_acc_x + ((neg[0] ^ i_ctl.op) ? hs : -hs);
            n_acc_y = i_acc_y + ((neg[1] ^ i_ctl.op) ? hs : -hs);
            n_acc_z = i_acc_z + ((neg[2] ^ i_ctl.op) ? hs : -hs);
        end
    end

    assign o_ready_up = !r_valid || i_ready_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_up && i_ctl.valid) begin
            r_ctl   <= n_ctl;
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_acc_z <= n_acc_z;
        end
    end

    always_comb begin
        o_ctl       = r_ctl;
        o_ctl.valid = r_valid;
    end

    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;
    assign o_acc_z = r_acc_z;

endmodule
